>>> rtl/multi_axis_stepper_step_generator_top_assert.svh
// assertion macros for the step generator checker
`ifndef MULTI_AXIS_STEPPER_STEP_GENERATOR_TOP_ASSERT_SVH
`define MULTI_AXIS_STEPPER_STEP_GENERATOR_TOP_ASSERT_SVH

// property checked outside reset
`define MASG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("step generator check failed");

// property checked on every edge, reset included
`define MASG_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("step generator reset check failed");

`endif

>>> rtl/masg_pkg.sv
// shared types, op codes and defaults for the step generator
package masg_pkg;

   localparam int AXES_DEFAULT      = 4;
   localparam int POS_WIDTH_DEFAULT = 32;

   localparam int OP_W     = 3;
   localparam int AXIS_W   = 2;
   localparam int AMOUNT_W = 32;
   localparam int MASK_W   = 4;
   localparam int APOS_W   = 32;

   localparam logic [OP_W-1:0] OP_TICK        = 3'd0;
   localparam logic [OP_W-1:0] OP_SET_TARGET  = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD_TARGET  = 3'd2;
   localparam logic [OP_W-1:0] OP_SUB_TARGET  = 3'd3;
   localparam logic [OP_W-1:0] OP_ADD_ALL     = 3'd4;
   localparam logic [OP_W-1:0] OP_ENABLE      = 3'd5;
   localparam logic [OP_W-1:0] OP_DISABLE     = 3'd6;

   typedef struct packed {
      logic [OP_W-1:0]            op;
      logic [AXIS_W-1:0]          axis;
      logic signed [AMOUNT_W-1:0] amount;
   } req_payload_type;

   typedef struct packed {
      logic [MASK_W-1:0]        step_mask;
      logic [MASK_W-1:0]        dir_bits;
      logic                     motors_on;
      logic signed [APOS_W-1:0] axis_position;
   } rsp_payload_type;

endpackage

>>> rtl/masg_stream_if.sv
// valid/ready stream channel carrying one payload per transfer
interface masg_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/multi_axis_stepper_step_generator_top.sv
// Step/direction generator for AXES axes. Every transfer on req_if (tick, target command or
// enable/disable) gives exactly one transfer on rsp_if with the step mask, direction levels,
// enable flag and the selected axis position after that item. One item is taken per clock:
// an input register feeds a single stage of per-axis compare and increment logic whose
// results land in the state registers and in the output register; the block keeps that
// rate for as long as rsp_if is not stalled. req_if.ready follows rsp_if.ready
// combinationally through the input stage.
module multi_axis_stepper_step_generator_top
   import masg_pkg::*;
#(
   parameter int AXES      = AXES_DEFAULT,
   parameter int POS_WIDTH = POS_WIDTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   masg_stream_if.sink   req_if,
   masg_stream_if.source rsp_if
);

   // input stage
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_ff;

   // output stage
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;

   logic advance, proc;

   // axis state
   logic [POS_WIDTH-1:0] cur_ff [AXES];
   logic [POS_WIDTH-1:0] cur_in [AXES];
   logic [POS_WIDTH-1:0] tgt_ff [AXES];
   logic [POS_WIDTH-1:0] tgt_in [AXES];
   logic [AXES-1:0]      dir_ff, dir_in;
   logic                 en_ff, en_in;

   logic [AXES-1:0]        step;
   logic [AXES-1:0]        sel;
   logic                   ax_ok;
   logic [POS_WIDTH-1:0]   amt_pos;
   logic [POS_WIDTH-1:0]   pos_sel;
   logic [AXES+MASK_W-1:0] dir_pad;

   assign advance       = !out_valid_ff || rsp_if.ready;
   assign proc          = s1_valid_ff && advance;
   assign req_if.ready  = !s1_valid_ff || advance;
   assign rsp_if.valid  = out_valid_ff;
   assign rsp_if.payload = out_ff;

   assign s1_valid_in  = req_if.ready ? req_if.valid : s1_valid_ff;
   assign out_valid_in = proc || (out_valid_ff && !rsp_if.ready);

   // sign-extend or truncate the amount to the position width
   assign amt_pos = POS_WIDTH'(s1_ff.amount);

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         sel[i] = (int'(s1_ff.axis) == i);
      end
      ax_ok = |sel;
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         cur_in[i] = cur_ff[i];
         tgt_in[i] = tgt_ff[i];
      end
      dir_in = dir_ff;
      en_in  = en_ff;
      step   = '0;
      if (proc) begin
         case (s1_ff.op)
            OP_TICK: begin
               if (en_ff) begin
                  for (int i = 0; i < AXES; i++) begin
                     if (cur_ff[i] != tgt_ff[i]) begin
                        step[i] = 1'b1;
                        if ($signed(tgt_ff[i]) > $signed(cur_ff[i])) begin
                           dir_in[i] = 1'b0;
                           cur_in[i] = cur_ff[i] + POS_WIDTH'(1);
                        end else begin
                           dir_in[i] = 1'b1;
                           cur_in[i] = cur_ff[i] - POS_WIDTH'(1);
                        end
                     end
                  end
               end
            end
            OP_SET_TARGET: begin
               for (int i = 0; i < AXES; i++) begin
                  if (en_ff && sel[i]) begin
                     tgt_in[i] = amt_pos;
                  end
               end
            end
            OP_ADD_TARGET: begin
               for (int i = 0; i < AXES; i++) begin
                  if (en_ff && sel[i]) begin
                     tgt_in[i] = tgt_ff[i] + amt_pos;
                  end
               end
            end
            OP_SUB_TARGET: begin
               for (int i = 0; i < AXES; i++) begin
                  if (en_ff && sel[i]) begin
                     tgt_in[i] = tgt_ff[i] - amt_pos;
                  end
               end
            end
            OP_ADD_ALL: begin
               // applies whether or not the motors are on
               for (int i = 0; i < AXES; i++) begin
                  tgt_in[i] = tgt_ff[i] + amt_pos;
               end
            end
            OP_ENABLE: begin
               en_in = 1'b1;
            end
            OP_DISABLE: begin
               en_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      pos_sel = '0;
      for (int i = 0; i < AXES; i++) begin
         if (sel[i]) begin
            pos_sel = pos_sel | cur_in[i];
         end
      end
      // axes missing below four report as moving toward negative
      dir_pad                = {{MASK_W{1'b1}}, dir_in};
      out_in.step_mask       = MASK_W'(step);
      out_in.dir_bits        = dir_pad[MASK_W-1:0];
      out_in.motors_on       = en_in;
      out_in.axis_position   = ax_ok ? APOS_W'(pos_sel) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            cur_ff[i] <= '0;
            tgt_ff[i] <= '0;
         end
         dir_ff <= '1;
         en_ff  <= 1'b1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < AXES; i++) begin
            cur_ff[i] <= cur_in[i];
            tgt_ff[i] <= tgt_in[i];
         end
         dir_ff <= dir_in;
         en_ff  <= en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_ff <= req_if.payload;
      end
      if (proc) begin
         out_ff <= out_in;
      end
   end

endmodule

>>> rtl/masg_checker.sv
// port-level assertions for the step generator, bound to its top level
`include "multi_axis_stepper_step_generator_top_assert.svh"

module masg_checker
   import masg_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // no result is left over once reset has been seen
   `MASG_ASSERT_ALWAYS(a_rsp_empty_after_reset, clock, reset |=> !rsp_valid)

   // a stalled result holds until its transfer
   `MASG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))

   // no step pulses with the motors off
   `MASG_ASSERT(a_no_step_disabled, clock, reset, rsp_valid && !rsp_payload.motors_on |-> rsp_payload.step_mask == '0)

   // an empty output stage never blocks the input side
   `MASG_ASSERT(a_ready_when_drained, clock, reset, !rsp_valid |-> req_ready)

endmodule

bind multi_axis_stepper_step_generator_top masg_checker u_masg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
